// File: rtl/pn2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared types, constants and arithmetic helpers of the 2-D gradient noise
// evaluator.
// ----------------------------------------------------------------------------
package pn2d_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int FRAC_BITS  = 16;

  localparam int ADDR_W   = $clog2(TABLE_SIZE);
  localparam int ENTRY_W  = 8;
  localparam int COORD_W  = 24;
  localparam int OUT_W    = 19;

  // Input tdata layout, lowest field first.
  localparam int IN_X_LSB   = 0;
  localparam int IN_Y_LSB   = IN_X_LSB + COORD_W;
  localparam int IN_IDX_LSB = IN_Y_LSB + COORD_W;
  localparam int IN_VAL_LSB = IN_IDX_LSB + ENTRY_W;
  localparam int IN_BITS    = IN_VAL_LSB + ENTRY_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Function codes carried in tuser.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Gradient selectors: the four diagonal directions.
  localparam logic [1:0] GRAD_PP = 2'd0;
  localparam logic [1:0] GRAD_MP = 2'd1;
  localparam logic [1:0] GRAD_PM = 2'd2;
  localparam logic [1:0] GRAD_MM = 2'd3;

  typedef logic [ADDR_W-1:0]                 addr_t;
  typedef logic [ENTRY_W-1:0]                entry_t;
  typedef logic [FRAC_BITS-1:0]              frac_t;
  typedef logic [FRAC_BITS+3:0]              poly_t;
  typedef logic [FRAC_BITS:0]                fade_t;
  typedef logic signed [FRAC_BITS+1:0]       delta_t;
  typedef logic signed [FRAC_BITS+2:0]       grad_t;
  typedef logic signed [FRAC_BITS+4:0]       wide_t;
  typedef logic signed [FRAC_BITS+5:0]       scaled_t;
  typedef logic signed [OUT_W-1:0]           noise_t;

  localparam poly_t   FADE_A0 = poly_t'(15 * (2 ** FRAC_BITS));
  localparam poly_t   FADE_C0 = poly_t'(10 * (2 ** FRAC_BITS));
  localparam delta_t  ONE_D   = delta_t'(2 ** FRAC_BITS);
  localparam scaled_t SAT_HI  = scaled_t'(2 ** (FRAC_BITS + 1));
  localparam scaled_t SAT_LO  = -SAT_HI;

  // (t * (15 - 6t)) >> F, the inner term of the quintic fade.
  function automatic poly_t fade_inner(frac_t t);
    poly_t                    a;
    logic [2*FRAC_BITS+3:0]   prod;
    a    = FADE_A0 - ((poly_t'(t) << 2) + (poly_t'(t) << 1));
    prod = {{(FRAC_BITS+4){1'b0}}, t} * {{FRAC_BITS{1'b0}}, a};
    return prod[2*FRAC_BITS+3:FRAC_BITS];
  endfunction

  // (a * b) >> F for two unsigned fractions.
  function automatic frac_t mul_hi(frac_t a, frac_t b);
    logic [2*FRAC_BITS-1:0] prod;
    prod = {{FRAC_BITS{1'b0}}, a} * {{FRAC_BITS{1'b0}}, b};
    return prod[2*FRAC_BITS-1:FRAC_BITS];
  endfunction

  // (t3 * c) >> F; the result never exceeds one.
  function automatic fade_t fade_final(frac_t t3, poly_t c);
    logic [2*FRAC_BITS+3:0] prod;
    prod = {{(FRAC_BITS+4){1'b0}}, t3} * {{FRAC_BITS{1'b0}}, c};
    return prod[2*FRAC_BITS:FRAC_BITS];
  endfunction

  function automatic grad_t grad_fx(logic [1:0] h, delta_t dx, delta_t dy);
    grad_t x;
    grad_t y;
    grad_t g;
    x = $signed({dx[FRAC_BITS+1], dx});
    y = $signed({dy[FRAC_BITS+1], dy});
    case (h)
      GRAD_PP: g = x + y;
      GRAD_MP: g = y - x;
      GRAD_PM: g = x - y;
      GRAD_MM: g = -x - y;
      default: g = x + y;
    endcase
    return g;
  endfunction

  function automatic wide_t widen(grad_t g);
    return $signed({{2{g[FRAC_BITS+2]}}, g});
  endfunction

  // floor(t * d / ONE): the arithmetic shift rounds toward minus infinity.
  function automatic scaled_t scale_fx(fade_t t, wide_t d);
    logic signed [2*FRAC_BITS+5:0] prod;
    prod = $signed({{(FRAC_BITS+5){1'b0}}, t}) *
           $signed({{(FRAC_BITS+1){d[FRAC_BITS+4]}}, d});
    return prod[2*FRAC_BITS+5:FRAC_BITS];
  endfunction

endpackage
`default_nettype wire

// File: rtl/pn2d_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn2d_ram
// Generic RAM with one write port and two registered read ports. A read at
// the address being written returns the old contents.
// ----------------------------------------------------------------------------
module pn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

// File: rtl/perlin_noise_2d_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perlin_noise_2d_eval
// Two-dimensional gradient noise at a fixed-point point, using a permutation
// table loaded by software.
// ----------------------------------------------------------------------------
// The pipeline has 8 register stages: stage registers 1 to 7 and the output.
// Throughput: one transaction per cycle unless out_tready stalls the pipeline.
// A load transaction writes the table in its own cycle and gives no result.
// Reset clears the stage valid bits only; table contents are undefined until
// written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module perlin_noise_2d_eval
  import pn2d_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // coord_x[23:0], coord_y[47:24], entry_index[55:48], entry_value[63:56]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // func
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // noise_value[18:0], zero padding above
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  // Input fields.
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  entry_t             in_idx;
  entry_t             in_val;
  logic               load_wr;

  assign in_x   = in_tdata[IN_X_LSB +: COORD_W];
  assign in_y   = in_tdata[IN_Y_LSB +: COORD_W];
  assign in_idx = in_tdata[IN_IDX_LSB +: ENTRY_W];
  assign in_val = in_tdata[IN_VAL_LSB +: ENTRY_W];

  // Stage valids and advance enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv_o;

  assign adv_o = !out_valid_r || out_tready;
  assign adv7  = !v7_r || adv_o;
  assign adv6  = !v6_r || adv7;
  assign adv5  = !v5_r || adv6;
  assign adv4  = !v4_r || adv5;
  assign adv3  = !v3_r || adv4;
  assign adv2  = !v2_r || adv3;
  assign adv1  = !v1_r || adv2;

  assign in_tready = adv1;
  assign load_wr   = in_tvalid && adv1 && (in_tuser == FUNC_LOAD);

  // The permutation table is kept in three identical banks that are all
  // written together, which gives six reads per cycle.
  addr_t  col_addr0, col_addr1;
  addr_t  yi1_r;
  addr_t  yi1_p;
  addr_t  hash_a0, hash_a1, hash_b0, hash_b1;
  entry_t px0, px1;
  entry_t h00, h01, h10, h11;

  assign col_addr0 = in_x[FRAC_BITS +: ADDR_W];
  assign col_addr1 = col_addr0 + addr_t'(1);

  pn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_col (
    .clk       (clk),
    .wr_en     (load_wr),
    .wr_addr   (addr_t'(in_idx)),
    .wr_data   (in_val),
    .rd_en     (adv1),
    .rd_addr_a (col_addr0),
    .rd_addr_b (col_addr1),
    .rd_data_a (px0),
    .rd_data_b (px1)
  );

  assign yi1_p   = yi1_r + addr_t'(1);
  assign hash_a0 = addr_t'(px0) + yi1_r;
  assign hash_a1 = addr_t'(px0) + yi1_p;
  assign hash_b0 = addr_t'(px1) + yi1_r;
  assign hash_b1 = addr_t'(px1) + yi1_p;

  pn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_h0 (
    .clk       (clk),
    .wr_en     (load_wr),
    .wr_addr   (addr_t'(in_idx)),
    .wr_data   (in_val),
    .rd_en     (adv2),
    .rd_addr_a (hash_a0),
    .rd_addr_b (hash_a1),
    .rd_data_a (h00),
    .rd_data_b (h01)
  );

  pn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_h1 (
    .clk       (clk),
    .wr_en     (load_wr),
    .wr_addr   (addr_t'(in_idx)),
    .wr_data   (in_val),
    .rd_en     (adv2),
    .rd_addr_a (hash_b0),
    .rd_addr_b (hash_b1),
    .rd_data_a (h10),
    .rd_data_b (h11)
  );

  // Pipeline payload registers.
  frac_t   xf1_r, yf1_r, xf2_r, yf2_r;
  poly_t   px_2_r, py_2_r, cx_3_r, cy_3_r;
  frac_t   sqx_2_r, sqy_2_r, cbx_3_r, cby_3_r;
  grad_t   g00_3_r, g01_3_r, g10_3_r, g11_3_r;
  grad_t   g00_4_r, g01_4_r, g10_4_r, g11_4_r;
  fade_t   u4_r, v4f_r, v5f_r, v6f_r;
  scaled_t m0_5_r, m1_5_r, mr_7_r;
  grad_t   g00_5_r, g01_5_r;
  wide_t   l0_6_r, dl_6_r, l0_7_r;
  noise_t  out_data_r;

  // Stage 2 combinational: corner offsets and gradients.
  delta_t dx0, dx1, dy0, dy1;
  assign dx0 = $signed({2'b00, xf2_r});
  assign dy0 = $signed({2'b00, yf2_r});
  assign dx1 = dx0 - ONE_D;
  assign dy1 = dy0 - ONE_D;

  // Stage 5 and 7 combinational: interpolation and saturation.
  wide_t   l0_c, l1_c;
  scaled_t r_c, r_sat;

  assign l0_c = widen(g00_5_r) + m0_5_r[FRAC_BITS+4:0];
  assign l1_c = widen(g01_5_r) + m1_5_r[FRAC_BITS+4:0];
  assign r_c  = $signed({l0_7_r[FRAC_BITS+4], l0_7_r}) + mr_7_r;

  always_comb begin
    r_sat = r_c;
    if (r_c > SAT_HI) begin
      r_sat = SAT_HI;
    end else if (r_c < SAT_LO) begin
      r_sat = SAT_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid && (in_tuser == FUNC_EVAL);
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
      if (adv6) v6_r <= v5_r;
      if (adv7) v7_r <= v6_r;
      if (adv_o) out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      xf1_r <= in_x[FRAC_BITS-1:0];
      yf1_r <= in_y[FRAC_BITS-1:0];
      yi1_r <= in_y[FRAC_BITS +: ADDR_W];
    end
    if (adv2) begin
      xf2_r   <= xf1_r;
      yf2_r   <= yf1_r;
      px_2_r  <= fade_inner(xf1_r);
      py_2_r  <= fade_inner(yf1_r);
      sqx_2_r <= mul_hi(xf1_r, xf1_r);
      sqy_2_r <= mul_hi(yf1_r, yf1_r);
    end
    if (adv3) begin
      cx_3_r  <= FADE_C0 - px_2_r;
      cy_3_r  <= FADE_C0 - py_2_r;
      cbx_3_r <= mul_hi(sqx_2_r, xf2_r);
      cby_3_r <= mul_hi(sqy_2_r, yf2_r);
      g00_3_r <= grad_fx(h00[1:0], dx0, dy0);
      g01_3_r <= grad_fx(h01[1:0], dx0, dy1);
      g10_3_r <= grad_fx(h10[1:0], dx1, dy0);
      g11_3_r <= grad_fx(h11[1:0], dx1, dy1);
    end
    if (adv4) begin
      u4_r    <= fade_final(cbx_3_r, cx_3_r);
      v4f_r   <= fade_final(cby_3_r, cy_3_r);
      g00_4_r <= g00_3_r;
      g01_4_r <= g01_3_r;
      g10_4_r <= g10_3_r;
      g11_4_r <= g11_3_r;
    end
    if (adv5) begin
      m0_5_r  <= scale_fx(u4_r, widen(g10_4_r) - widen(g00_4_r));
      m1_5_r  <= scale_fx(u4_r, widen(g11_4_r) - widen(g01_4_r));
      g00_5_r <= g00_4_r;
      g01_5_r <= g01_4_r;
      v5f_r   <= v4f_r;
    end
    if (adv6) begin
      l0_6_r <= l0_c;
      dl_6_r <= l1_c - l0_c;
      v6f_r  <= v5f_r;
    end
    if (adv7) begin
      l0_7_r <= l0_6_r;
      mr_7_r <= scale_fx(v6f_r, dl_6_r);
    end
    if (adv_o) begin
      out_data_r <= r_sat[OUT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_data_r};

`ifndef NO_ASSERTIONS
  // A load transaction never enters the evaluation pipeline.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_LOAD) |=> !v1_r)
    else $error("load transaction entered the pipeline");

  // Results stay within the saturation bounds.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_data_r) <= $signed(SAT_HI[OUT_W-1:0])) &&
                    ($signed(out_data_r) >= $signed(SAT_LO[OUT_W-1:0])))
    else $error("noise result outside saturation range");

  // A stalled stage keeps its payload.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r && !adv6 |=> $stable(l0_6_r) && $stable(dl_6_r))
    else $error("stalled stage payload changed");

  // With every stage full and the output stalled, no transaction is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && v4_r && v5_r && v6_r && v7_r &&
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline is full");
`endif

endmodule
`default_nettype wire

// File: verif/tb_perlin_noise_2d_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perlin_noise_2d_eval
// Self-checking bench for the 2-D gradient noise evaluator. It loads the
// permutation table, then streams directed and random points and table
// reloads under random flow control on both sides. Every noise sample is
// compared with a fixed-point model of the evaluator kept inside the bench.
// ----------------------------------------------------------------------------
module tb_perlin_noise_2d_eval
  import pn2d_pkg::*;
();

  localparam longint ONE          = longint'(1) << FRAC_BITS;
  localparam int     LONG_HOLD    = 300;
  localparam int     STALL_LIMIT  = 3000;
  localparam int     DRAIN_CYCLES = 20;
  localparam int     RANDOM_ITEMS = 700;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Bench copy of the permutation table and the samples still in flight.
  entry_t      perm_copy [TABLE_SIZE];
  noise_t      pending_noise [$];

  bit          tx_gaps_on    = 1'b0;
  bit          rx_stalls_on  = 1'b0;
  bit          hold_request  = 1'b0;
  int unsigned fail_count    = 0;
  int unsigned load_count    = 0;
  int unsigned eval_count    = 0;
  int unsigned checked_count = 0;
  int unsigned quiet_cycles  = 0;

  perlin_noise_2d_eval i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Quintic fade 6t^5 - 15t^4 + 10t^3, every product truncated.
  function automatic longint fade_curve(longint t);
    longint a;
    longint p;
    longint c;
    longint t2;
    longint t3;
    a  = 15 * ONE - 6 * t;
    p  = (t * a) >>> FRAC_BITS;
    c  = 10 * ONE - p;
    t2 = (t * t) >>> FRAC_BITS;
    t3 = (t2 * t) >>> FRAC_BITS;
    return (t3 * c) >>> FRAC_BITS;
  endfunction

  function automatic longint corner_dot(logic [1:0] h, longint dx, longint dy);
    case (h)
      GRAD_PP: return dx + dy;
      GRAD_MP: return dy - dx;
      GRAD_PM: return dx - dy;
      default: return -dx - dy;
    endcase
  endfunction

  // The arithmetic shift floors, matching the block's truncation.
  function automatic longint blend(longint a, longint b, longint t);
    return a + ((t * (b - a)) >>> FRAC_BITS);
  endfunction

  function automatic noise_t noise_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    addr_t      xi;
    addr_t      yi;
    addr_t      x1;
    addr_t      y1;
    entry_t     px0;
    entry_t     px1;
    logic [1:0] h00;
    logic [1:0] h01;
    logic [1:0] h10;
    logic [1:0] h11;
    longint     xf;
    longint     yf;
    longint     u;
    longint     v;
    longint     l0;
    longint     l1;
    longint     r;
    xi  = x[COORD_W-1:FRAC_BITS];
    yi  = y[COORD_W-1:FRAC_BITS];
    x1  = xi + addr_t'(1);
    y1  = yi + addr_t'(1);
    xf  = longint'(x[FRAC_BITS-1:0]);
    yf  = longint'(y[FRAC_BITS-1:0]);
    u   = fade_curve(xf);
    v   = fade_curve(yf);
    px0 = perm_copy[xi];
    px1 = perm_copy[x1];
    // Sums are taken at table width, so they wrap modulo the table size.
    h00 = perm_copy[addr_t'(px0 + yi)][1:0];
    h01 = perm_copy[addr_t'(px0 + y1)][1:0];
    h10 = perm_copy[addr_t'(px1 + yi)][1:0];
    h11 = perm_copy[addr_t'(px1 + y1)][1:0];
    l0  = blend(corner_dot(h00, xf, yf), corner_dot(h10, xf - ONE, yf), u);
    l1  = blend(corner_dot(h01, xf, yf - ONE), corner_dot(h11, xf - ONE, yf - ONE), u);
    r   = blend(l0, l1, v);
    if (r > 2 * ONE) r = 2 * ONE;
    if (r < -2 * ONE) r = -2 * ONE;
    return noise_t'(r);
  endfunction

  // Called at a falling edge; returns at the falling edge after the
  // transaction with in_tvalid still high, so the next call can either
  // present new data at once or lower it for a gap.
  task automatic send_item(input logic func, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input entry_t idx,
                           input entry_t val);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {val, idx, y, x};
    do @(posedge clk); while (!in_tready);
    if (func == FUNC_LOAD) begin
      perm_copy[idx] = val;
      load_count++;
    end else begin
      pending_noise.push_back(noise_at(x, y));
      eval_count++;
    end
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_noise.size() != 0) @(negedge clk);
  endtask

  // Fill every entry with a shuffled permutation, in shuffled order.
  task automatic test_table_load();
    entry_t      shuffled [TABLE_SIZE];
    entry_t      order [TABLE_SIZE];
    entry_t      tmp;
    int unsigned j;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      shuffled[i] = entry_t'(i);
      order[i]    = entry_t'(i);
    end
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      j           = $urandom_range(0, i);
      tmp         = shuffled[i];
      shuffled[i] = shuffled[j];
      shuffled[j] = tmp;
      j           = $urandom_range(0, i);
      tmp         = order[i];
      order[i]    = order[j];
      order[j]    = tmp;
    end
    for (int i = 0; i < TABLE_SIZE; i++)
      send_item(FUNC_LOAD, COORD_W'($urandom), COORD_W'($urandom), order[i],
                shuffled[order[i]]);
  endtask

  // Route cell (0,0) through entries 10, 11, 20 and 21 and rotate the
  // gradient selectors there, so each corner sees all four directions.
  task automatic test_gradient_directions();
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    send_item(FUNC_LOAD, '0, '0, entry_t'(0), entry_t'(10));
    send_item(FUNC_LOAD, '0, '0, entry_t'(1), entry_t'(20));
    for (int k = 0; k < 4; k++) begin
      send_item(FUNC_LOAD, '0, '0, entry_t'(10), entry_t'(k % 4));
      send_item(FUNC_LOAD, '0, '0, entry_t'(11), entry_t'((k + 1) % 4));
      send_item(FUNC_LOAD, '0, '0, entry_t'(20), entry_t'((k + 2) % 4));
      send_item(FUNC_LOAD, '0, '0, entry_t'(21), entry_t'((k + 3) % 4));
      x = {8'd0, 16'($urandom)};
      y = {8'd0, 16'($urandom)};
      send_item(FUNC_EVAL, x, y, entry_t'($urandom), entry_t'($urandom));
    end
  endtask

  // Lattice points, fractions at their limits and wrap of the last cell.
  task automatic test_coordinate_extremes();
    logic [COORD_W-1:0] xs [8] = '{24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'hFF8000,
                                   24'h000000, 24'hFFFFFF, 24'h010000, 24'h808000};
    logic [COORD_W-1:0] ys [8] = '{24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'h000000,
                                   24'hFF8000, 24'h000001, 24'h7FFFFF, 24'h7F7FFF};
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    for (int i = 0; i < 8; i++)
      send_item(FUNC_EVAL, xs[i], ys[i], '1, '0);
  endtask

  // The result side holds off for a long stretch while points keep coming,
  // so the pipeline fills and in_tready must drop.
  task automatic test_backpressure();
    settle();
    tx_gaps_on   = 1'b0;
    hold_request = 1'b1;
    repeat (60)
      send_item(FUNC_EVAL, COORD_W'($urandom), COORD_W'($urandom),
                entry_t'($urandom), entry_t'($urandom));
  endtask

  task automatic test_random_mix();
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 125 == 0) begin
        tx_gaps_on   = ($urandom_range(0, 1) == 1);
        rx_stalls_on = ($urandom_range(0, 1) == 1);
      end
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        send_item(FUNC_LOAD, x, y, entry_t'($urandom), entry_t'($urandom));
      end else begin
        case ($urandom_range(0, 7))
          0: x[FRAC_BITS-1:0] = '0;
          1: y[FRAC_BITS-1:0] = '1;
          2: x[COORD_W-1:FRAC_BITS] = '1;
          3: y[COORD_W-1:FRAC_BITS] = '1;
          default: ;
        endcase
        send_item(FUNC_EVAL, x, y, entry_t'($urandom), entry_t'($urandom));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_tready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 13) : 0;
      if (hold_request) begin
        stall        = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_result
    noise_t oldest;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_noise.size() == 0) begin
        $error("noise_value with no evaluation pending: actual %0d",
               $signed(out_tdata[OUT_W-1:0]));
        fail_count++;
      end else begin
        oldest = pending_noise.pop_front();
        checked_count++;
        if (out_tdata[OUT_W-1:0] !== oldest) begin
          $error("noise_value mismatch: expected %0d, actual %0d", oldest,
                 $signed(out_tdata[OUT_W-1:0]));
          fail_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:OUT_W] !== '0) begin
          $error("out_tdata padding mismatch: expected 0, actual %h",
                 out_tdata[OUT_TDATA_W-1:OUT_W]);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = FUNC_LOAD;
    in_tdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_table_load();
    test_gradient_directions();
    test_coordinate_extremes();
    test_backpressure();
    test_random_mix();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_noise.size() != 0) begin
      $error("%0d noise samples never arrived", pending_noise.size());
      fail_count++;
    end
    $display("Covered %0d table writes and %0d noise points, %0d samples checked,",
             load_count, eval_count, checked_count);
    $display("including a %0d-cycle result hold-off with the input stalled.", LONG_HOLD);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
